FILE: rtl/core/huffman_tree_byte_decoder_defines.svh
// Assertion macros for the Huffman tree byte decoder.
// Used by modules that check their own logic; expects clk_i and rst_ni in scope.
`ifndef HUFFMAN_TREE_BYTE_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_BYTE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HTBD_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("htbd assertion failed");

// next-cycle implication
`define HTBD_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("htbd assertion failed");

`else

`define HTBD_ASSERT(lbl, pre, post)
`define HTBD_ASSERT_NXT(lbl, pre, post)

`endif

`endif

FILE: rtl/core/htbd_pkg.sv
// Shared types and constants for the Huffman tree byte decoder.
// No dependencies.
package htbd_pkg;

  localparam int NUM_NODES = 255;
  localparam int NODE_W    = 8;
  localparam int CHILD_W   = 9;
  localparam int ENTRY_W   = 2 * CHILD_W;
  localparam int LEN_W     = 24;
  localparam int SYM_W     = 8;
  localparam int BITCNT_W  = 3;

  localparam logic [NODE_W-1:0]   HEAD_NODE = 8'd254;
  localparam logic [NODE_W-1:0]   NODE_LIMIT = NODE_W'(NUM_NODES);
  localparam logic [BITCNT_W-1:0] LAST_BIT  = 3'd7;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } walk_state_e;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_run;
    logic             stream_done;
  } result_t;

  typedef struct packed {
    logic                en;
    logic [NODE_W-1:0]   addr;
    logic [ENTRY_W-1:0]  data;
  } ram_wr_t;

endpackage

FILE: rtl/core/htbd_node_ram.sv
// Node table: one write port, one read port with registered data.
// Depends on htbd_pkg.
module htbd_node_ram import htbd_pkg::*; (
  input  logic               clk_i,
  input  ram_wr_t            wr_i,
  input  logic [NODE_W-1:0]  rd_addr_i,
  output logic [ENTRY_W-1:0] rd_data_o
);

  logic [ENTRY_W-1:0] mem [NUM_NODES];
  logic [ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/htbd_out_reg.sv
// Output register for decoded results.
// Depends on htbd_pkg.
module htbd_out_reg import htbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    can_push_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign can_push_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: rtl/core/htbd_walker.sv
// Tree walker: bit-serial byte shifter, node pointer, stream counters, control FSM.
// Depends on htbd_pkg and huffman_tree_byte_decoder_defines.svh.
`include "huffman_tree_byte_decoder_defines.svh"

module htbd_walker import htbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [NODE_W-1:0]  node_index_i,
  input  logic [CHILD_W-1:0] zero_child_i,
  input  logic [CHILD_W-1:0] one_child_i,
  input  logic [SYM_W-1:0]   data_byte_i,
  input  logic               first_byte_i,
  input  logic               last_byte_i,
  input  logic [LEN_W-1:0]   len_i,
  output ram_wr_t            wr_o,
  output logic [NODE_W-1:0]  rd_addr_o,
  input  logic [ENTRY_W-1:0] rd_data_i,
  output logic               push_o,
  output result_t            push_data_o,
  input  logic               can_push_i
);

  walk_state_e state_q, state_d;

  logic [NODE_W-1:0]   node_q, node_d;
  logic [LEN_W-1:0]    cnt_q, cnt_d;
  logic                ended_q, ended_d;
  logic [SYM_W-1:0]    shift_q, shift_d;
  logic [BITCNT_W-1:0] bitcnt_q, bitcnt_d;
  logic                last_q, last_d;
  logic                pend_valid_q, pend_valid_d;
  logic                pend_done_q, pend_done_d;
  logic [SYM_W-1:0]    pend_sym_q, pend_sym_d;

  logic [CHILD_W-1:0]  child;
  logic [NODE_W-1:0]   target;
  logic                is_lit;
  logic                need_push;
  logic                hold;
  logic [LEN_W-1:0]    cnt_inc;
  logic                len_hit;
  logic                bit_end;
  logic                accept;
  logic                ended_eff;
  logic [LEN_W-1:0]    cnt_eff;
  logic                start;

  // current bit picks a child of the node read last cycle
  assign child     = shift_q[0] ? rd_data_i[ENTRY_W-1:CHILD_W] : rd_data_i[CHILD_W-1:0];
  assign is_lit    = !child[CHILD_W-1];
  assign target    = child[NODE_W-1:0];
  assign cnt_inc   = cnt_q + 1'b1;
  assign len_hit   = cnt_inc >= len_i;
  assign bit_end   = bitcnt_q == LAST_BIT;
  assign need_push = ((state_q == ST_RUN) && is_lit && pend_valid_q) || (state_q == ST_FLUSH);
  assign hold      = need_push && !can_push_i;

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign ended_eff  = ended_q && !first_byte_i;
  assign cnt_eff    = first_byte_i ? '0 : cnt_q;
  assign start      = accept && (func_i == FUNC_DECODE) && !ended_eff && (cnt_eff < len_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (!hold) begin
          if (is_lit && len_hit) begin
            state_d = ST_FLUSH;
          end else if (bit_end) begin
            state_d = (pend_valid_q || is_lit) ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (can_push_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    node_d       = node_q;
    cnt_d        = cnt_q;
    ended_d      = ended_q;
    shift_d      = shift_q;
    bitcnt_d     = bitcnt_q;
    last_d       = last_q;
    pend_valid_d = pend_valid_q;
    pend_done_d  = pend_done_q;
    pend_sym_d   = pend_sym_q;
    push_o       = 1'b0;
    push_data_o  = '{symbol: pend_sym_q, last_of_run: 1'b0, stream_done: 1'b0};
    wr_o.en      = accept && (func_i == FUNC_LOAD) && (node_index_i < NODE_LIMIT);
    wr_o.addr    = node_index_i;
    wr_o.data    = {one_child_i, zero_child_i};

    case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == FUNC_DECODE)) begin
          if (first_byte_i) begin
            node_d  = HEAD_NODE;
            cnt_d   = '0;
            ended_d = 1'b0;
          end
          if (!ended_eff && (cnt_eff >= len_i)) begin
            ended_d = 1'b1;
          end
          if (start) begin
            shift_d      = data_byte_i;
            bitcnt_d     = '0;
            last_d       = last_byte_i;
            pend_valid_d = 1'b0;
            pend_done_d  = 1'b0;
          end
        end
      end
      ST_RUN: begin
        if (!hold) begin
          shift_d  = shift_q >> 1;
          bitcnt_d = bitcnt_q + 1'b1;
          if (is_lit) begin
            push_o       = pend_valid_q;
            cnt_d        = cnt_inc;
            node_d       = HEAD_NODE;
            pend_sym_d   = child[SYM_W-1:0];
            pend_valid_d = 1'b1;
            if (len_hit) begin
              ended_d     = 1'b1;
              pend_done_d = 1'b1;
            end
          end else begin
            node_d = (target < NODE_LIMIT) ? target : HEAD_NODE;
          end
          // last byte ended without any symbol
          if (bit_end && !is_lit && !pend_valid_q && last_q) begin
            ended_d = 1'b1;
            node_d  = HEAD_NODE;
          end
        end
      end
      ST_FLUSH: begin
        push_data_o = '{symbol: pend_sym_q, last_of_run: 1'b1,
                        stream_done: pend_done_q || last_q};
        if (can_push_i) begin
          push_o       = 1'b1;
          pend_valid_d = 1'b0;
          if (last_q) begin
            ended_d = 1'b1;
            node_d  = HEAD_NODE;
          end
        end
      end
      default: ;
    endcase
  end

  // read the node the walk is about to stand on
  assign rd_addr_o = node_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_q       <= HEAD_NODE;
      cnt_q        <= '0;
      ended_q      <= 1'b0;
      bitcnt_q     <= '0;
      last_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_done_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_q       <= node_d;
      cnt_q        <= cnt_d;
      ended_q      <= ended_d;
      bitcnt_q     <= bitcnt_d;
      last_q       <= last_d;
      pend_valid_q <= pend_valid_d;
      pend_done_q  <= pend_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q    <= shift_d;
    pend_sym_q <= pend_sym_d;
  end

  `HTBD_ASSERT(a_node_in_range, 1'b1, node_q < NODE_LIMIT)
  `HTBD_ASSERT(a_idle_no_pending, state_q == ST_IDLE, !pend_valid_q)
  `HTBD_ASSERT(a_flush_has_pending, state_q == ST_FLUSH, pend_valid_q)
  `HTBD_ASSERT_NXT(a_hold_keeps_walk, (state_q == ST_RUN) && hold,
                   $stable(bitcnt_q) && $stable(node_q) && $stable(cnt_q))

endmodule

FILE: rtl/core/huffman_tree_byte_decoder.sv
// Huffman tree byte decoder. A load request (func_i = 0) writes one node of the
// 255-entry tree table. A decode request (func_i = 1) walks the tree one
// compressed bit per cycle while the output is not stalled, LSB first, starting
// from node 254 at stream start and after each literal, and emits one result per
// literal reached. A decode request that the ended stream drops, or that finds
// output_length already met, starts no walk. A decode request that walks takes
// 8 bit steps, then a flush of the held symbol when the byte yields one, then a
// return to idle, where the next request is taken. When output_length is reached
// the walk stops at that bit and flushes the held symbol. Output stall can hold
// the walk and the flush. The bit loop is set by the node table's registered
// read: each bit's child selects the next node read. Decode requests after the
// stream ends (length reached or last byte done) are dropped until one with
// first_byte_i set. output_length is written through cfg_we_i / cfg_wdata_i;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Depends on htbd_pkg, htbd_node_ram, htbd_out_reg, htbd_walker.
module huffman_tree_byte_decoder import htbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [LEN_W-1:0]   cfg_wdata_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [NODE_W-1:0]  node_index_i,
  input  logic [CHILD_W-1:0] zero_child_i,
  input  logic [CHILD_W-1:0] one_child_i,
  input  logic [SYM_W-1:0]   data_byte_i,
  input  logic               first_byte_i,
  input  logic               last_byte_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SYM_W-1:0]   symbol_o,
  output logic               last_of_run_o,
  output logic               stream_done_o
);

  logic [LEN_W-1:0]   len_q, len_d;
  ram_wr_t            ram_wr;
  logic [NODE_W-1:0]  ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic               push;
  result_t            push_data;
  logic               can_push;
  result_t            out_data;

  // output_length register
  assign len_d = cfg_we_i ? cfg_wdata_i : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // tree table
  htbd_node_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // bit-serial walk and stream control
  htbd_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .node_index_i (node_index_i),
    .zero_child_i (zero_child_i),
    .one_child_i  (one_child_i),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .len_i        (len_q),
    .wr_o         (ram_wr),
    .rd_addr_o    (ram_rd_addr),
    .rd_data_i    (ram_rd_data),
    .push_o       (push),
    .push_data_o  (push_data),
    .can_push_i   (can_push)
  );

  // result register; the walker holds one more symbol so last_of_run is known
  htbd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .can_push_o  (can_push),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign symbol_o      = out_data.symbol;
  assign last_of_run_o = out_data.last_of_run;
  assign stream_done_o = out_data.stream_done;

endmodule
